@@ sv/wma_pkg.sv @@
// Shared types and constants for the windowed moving average block.
`default_nettype none
package wma_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ sv/wma_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module wma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/wma_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module wma_div #(
  parameter int DIVIDEND_W = 38,
  parameter int DIVISOR_W  = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output wma_pkg::div_stat_t         stat,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W);
  localparam logic [CW-1:0] LAST = CW'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [CW-1:0]         cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    diff;
  logic                  qbit;
  logic [DIVISOR_W-1:0]  rem_next;

  assign rem_shift = {rem, quo[DIVIDEND_W-1]};
  assign diff      = rem_shift - {1'b0, dsr};
  assign qbit      = (rem_shift >= {1'b0, dsr});
  assign rem_next  = qbit ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIVIDEND_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = quo;

endmodule
`default_nettype wire

@@ sv/windowed_moving_average.sv @@
// Moving average of the last WINDOW unsigned samples, kept in a ring RAM.
//
// Input stream (s_tvalid/s_tready/s_tdata) carries one 32-bit sample per
// request; output stream (m_tvalid/m_tready/m_tdata) carries one 32-bit mean
// per request: running sum over the window divided by min(samples seen,
// WINDOW), truncated.
// Each request reads the oldest ring entry in ST_READ, then the divider works
// through the sum bit by bit (32 + clog2(WINDOW) bits, 38 at the default
// WINDOW) producing the quotient; ST_DONE moves it to the output reg.
// One sample is taken at a time: the next is accepted only after the
// previous mean has been moved to the output register.
// s_tready is high only while no sample is in work; a finished mean waits in
// the output register, and the next sample may be accepted meanwhile.
// A stalled receiver holds the next mean in the divider until the output
// register frees up.
// Synchronous reset empties the window: sum, pointer and fill count clear,
// and ring entries that were never written since reset read as zero through
// the fill count, so no clearing pass is needed.
`default_nettype none
module windowed_moving_average #(
  parameter int WINDOW = 60
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata    // [31:0] mean
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = wma_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                       state;
  logic [PTR_W-1:0]             ptr;
  logic [CNT_W-1:0]             fill;
  logic [SUM_W-1:0]             sum;
  logic [wma_pkg::SAMPLE_W-1:0] sample;
  logic [wma_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [wma_pkg::SAMPLE_W-1:0] old;
  logic                         full;
  logic [SUM_W-1:0]             sum_next;
  logic [CNT_W-1:0]             fill_next;
  logic [PTR_W-1:0]             ptr_next;
  logic                         div_start;
  wma_pkg::div_stat_t           div_stat;
  logic [SUM_W-1:0]             quotient;

  assign s_tready  = (state == ST_IDLE);
  assign full      = (fill == CNT_FULL);
  assign old       = full ? ram_rdata : '0;
  assign sum_next  = sum - SUM_W'(old) + SUM_W'(sample);
  assign fill_next = full ? fill : fill + 1'b1;
  assign ptr_next  = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
  assign div_start = (state == ST_READ);

  wma_ram #(
    .WIDTH (wma_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (ptr),
    .wdata (sample),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  wma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (fill_next),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ptr      <= '0;
      fill     <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sample <= s_tdata;
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          sum   <= sum_next;
          fill  <= fill_next;
          ptr   <= ptr_next;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= quotient[wma_pkg::MEAN_W-1:0];
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_FULL)
    else $error("fill count above window");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !full |-> (CNT_W'(ptr) == fill))
    else $error("write pointer out of step with fill count");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("mean presented without a finished divide");
`endif

endmodule
`default_nettype wire
